FILE: design/bth_pkg.sv
`timescale 1ns / 1ps
package bth_pkg;

    // Fixed field widths
    localparam int BIN_W     = 14;
    localparam int ADDR_W    = 20;  // address width for the largest supported bin count
    localparam int EVT_INC_W = 33;  // size decrease can reach 2^31 plus a bin index
    localparam int CNT_W     = 64;
    localparam int OUT_W     = 63;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;

    // Command codes
    localparam logic CMD_LEVEL = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Side codes
    localparam logic SIDE_ASK = 1'b0;
    localparam logic SIDE_BID = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic               side;
        logic [2:0]         level;
        logic signed [31:0] prev_price;
        logic signed [31:0] prev_size;
        logic signed [31:0] cur_price;
        logic signed [31:0] cur_size;
        logic [BIN_W-1:0]   bin;
    } in_item_t;

    typedef struct packed {
        logic [OUT_W-1:0] bin_exposure;
        logic [OUT_W-1:0] bin_events;
    } out_item_t;

    typedef enum logic {
        OP_UPDATE,
        OP_READ
    } op_kind_t;

    // One histogram operation from the classifier to the update engine
    typedef struct packed {
        op_kind_t             kind;
        logic [ADDR_W-1:0]    addr;
        logic                 oob;
        logic [ADDR_W-1:0]    exp_inc;
        logic [EVT_INC_W-1:0] evt_inc;
    } op_t;

endpackage

FILE: design/bth_front.sv
`timescale 1ns / 1ps
module bth_front import bth_pkg::*; #(
    parameter int BINS   = 16384,
    parameter int LEVELS = 8
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    input  logic     q_full,
    input  logic     clr_busy,
    output logic     push,
    output op_t      push_op
);

    localparam int AW = $clog2(BINS);

    logic signed [31:0] best_price_reg, best_price_next;
    logic [AW-1:0]      best_size_reg, best_size_next;
    logic               active_reg, active_next;

    logic               accept;
    logic               lvl0;
    logic               ps_ok;
    logic signed [31:0] eff_price;
    logic [AW-1:0]      eff_size;
    logic               eff_active;
    logic               scan;
    logic               better;
    logic               equal;
    logic signed [33:0] size_ext;
    logic signed [33:0] cs_ext;
    logic signed [33:0] dec;
    logic               have_evt;
    logic               scan_end;
    logic [EVT_INC_W-1:0] evt_inc;

    assign s_ready = !clr_busy && !q_full;
    assign accept  = s_valid && s_ready;

    // Pick the best level of the previous book
    always_comb begin
        lvl0       = (s_data.level == 3'd0);
        ps_ok      = (s_data.prev_size > 0) && (s_data.prev_size < BINS);
        eff_price  = lvl0 ? s_data.prev_price : best_price_reg;
        eff_size   = lvl0 ? (ps_ok ? s_data.prev_size[AW-1:0] : '0) : best_size_reg;
        eff_active = lvl0 ? ps_ok : active_reg;
        scan       = eff_active && (int'(s_data.level) < LEVELS);
    end

    // Classify the current level against the previous best
    always_comb begin
        if (s_data.side == SIDE_BID) begin
            better = s_data.cur_price > eff_price;
        end else begin
            better = s_data.cur_price < eff_price;
        end
        equal    = (s_data.cur_price == eff_price);
        size_ext = $signed({{(34-AW){1'b0}}, eff_size});
        cs_ext   = $signed({{2{s_data.cur_size[31]}}, s_data.cur_size});
        dec      = size_ext - cs_ext;
        have_evt = 1'b0;
        scan_end = 1'b0;
        evt_inc  = '0;
        if (scan) begin
            if (s_data.cur_size == 32'sd0) begin
                scan_end = 1'b1;
            end else if (!better) begin
                scan_end = 1'b1;
                if (equal) begin
                    if (dec > 34'sd0) begin
                        have_evt = 1'b1;
                        evt_inc  = dec[EVT_INC_W-1:0];
                    end
                end else begin
                    have_evt = 1'b1;
                    evt_inc  = EVT_INC_W'(eff_size);
                end
            end
        end
    end

    // Build the operation and the next scan state
    always_comb begin
        best_price_next = best_price_reg;
        best_size_next  = best_size_reg;
        active_next     = active_reg;
        push            = 1'b0;
        push_op.kind    = OP_UPDATE;
        push_op.addr    = ADDR_W'(eff_size);
        push_op.oob     = 1'b0;
        push_op.exp_inc = '0;
        push_op.evt_inc = evt_inc;
        if (accept) begin
            if (s_data.cmd == CMD_READ) begin
                push            = 1'b1;
                push_op.kind    = OP_READ;
                push_op.addr    = ADDR_W'(s_data.bin);
                push_op.oob     = int'(s_data.bin) >= BINS;
                push_op.evt_inc = '0;
            end else begin
                best_price_next = eff_price;
                best_size_next  = eff_size;
                active_next     = eff_active && !scan_end;
                if (lvl0 && ps_ok) begin
                    push_op.exp_inc = ADDR_W'(eff_size);
                end
                push = (lvl0 && ps_ok) || have_evt;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_price_reg <= '0;
            best_size_reg  <= '0;
            active_reg     <= 1'b0;
        end else begin
            best_price_reg <= best_price_next;
            best_size_reg  <= best_size_next;
            active_reg     <= active_next;
        end
    end

endmodule

FILE: design/bth_queue.sv
`timescale 1ns / 1ps
module bth_queue import bth_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    input  logic pop,
    output logic q_valid,
    output op_t  q_op
);

    op_t                entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]   count_reg, count_next;

    assign full    = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_op    = entry_reg[rd_ptr_reg];

    // Advance pointers and the fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold entries
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

FILE: design/bth_back.sv
`timescale 1ns / 1ps
module bth_back import bth_pkg::*; #(
    parameter int BINS = 16384
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    input  op_t       q_op,
    output logic      pop,
    output logic      clr_busy,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int AW = $clog2(BINS);

    logic [CNT_W-1:0] exp_mem [BINS];
    logic [CNT_W-1:0] evt_mem [BINS];

    logic             clr_busy_reg, clr_busy_next;
    logic [AW-1:0]    clr_addr_reg, clr_addr_next;

    logic             s2_valid_reg, s2_valid_next;
    op_t              s2_op_reg;
    logic [CNT_W-1:0] exp_rd_reg;
    logic [CNT_W-1:0] evt_rd_reg;

    logic             lw_valid_reg;
    logic [AW-1:0]    lw_addr_reg;
    logic [CNT_W-1:0] lw_exp_reg;
    logic [CNT_W-1:0] lw_evt_reg;

    logic             m_valid_reg, m_valid_next;
    out_item_t        m_data_reg;

    logic             out_free;
    logic             s2_adv;
    logic             s2_fire;
    logic             upd_fire;
    logic             rd_fire;
    logic [AW-1:0]    s2_addr;
    logic [CNT_W-1:0] exp_base;
    logic [CNT_W-1:0] evt_base;
    logic [CNT_W-1:0] exp_sum;
    logic [CNT_W-1:0] evt_sum;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [CNT_W-1:0] wr_exp;
    logic [CNT_W-1:0] wr_evt;

    assign clr_busy = clr_busy_reg;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Stall the update stage only when a read result has nowhere to go
    always_comb begin
        out_free = !m_valid_reg || m_ready;
        s2_adv   = !s2_valid_reg || (s2_op_reg.kind != OP_READ) || out_free;
        pop      = !clr_busy_reg && q_valid && s2_adv;
        s2_fire  = s2_valid_reg && s2_adv;
        upd_fire = s2_fire && (s2_op_reg.kind == OP_UPDATE);
        rd_fire  = s2_fire && (s2_op_reg.kind == OP_READ);
        s2_addr  = s2_op_reg.addr[AW-1:0];
    end

    // Forward the last write over the stale read data
    always_comb begin
        if (lw_valid_reg && (lw_addr_reg == s2_addr)) begin
            exp_base = lw_exp_reg;
            evt_base = lw_evt_reg;
        end else begin
            exp_base = exp_rd_reg;
            evt_base = evt_rd_reg;
        end
        exp_sum = exp_base + CNT_W'(s2_op_reg.exp_inc);
        evt_sum = evt_base + CNT_W'(s2_op_reg.evt_inc);
    end

    // Select the write: clearing pass first, then counter updates
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = s2_addr;
        wr_exp  = exp_sum;
        wr_evt  = evt_sum;
        if (clr_busy_reg) begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_exp  = '0;
            wr_evt  = '0;
        end else if (upd_fire) begin
            wr_en = 1'b1;
        end
    end

    // Next control state
    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(BINS - 1)) begin
                clr_busy_next = 1'b0;
            end
        end
        if (pop) begin
            s2_valid_next = 1'b1;
        end else if (s2_adv) begin
            s2_valid_next = 1'b0;
        end else begin
            s2_valid_next = s2_valid_reg;
        end
        if (rd_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            s2_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
            if (wr_en) begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    // Read both histograms on issue
    always_ff @(posedge aclk) begin
        if (pop) begin
            s2_op_reg  <= q_op;
            exp_rd_reg <= exp_mem[q_op.addr[AW-1:0]];
            evt_rd_reg <= evt_mem[q_op.addr[AW-1:0]];
        end
    end

    // Write both histograms and remember the write for forwarding
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            exp_mem[wr_addr] <= wr_exp;
            evt_mem[wr_addr] <= wr_evt;
            lw_addr_reg      <= wr_addr;
            lw_exp_reg       <= wr_exp;
            lw_evt_reg       <= wr_evt;
        end
    end

    // Load the result register
    always_ff @(posedge aclk) begin
        if (rd_fire) begin
            if (s2_op_reg.oob) begin
                m_data_reg <= '0;
            end else begin
                m_data_reg.bin_exposure <= exp_base[OUT_W-1:0];
                m_data_reg.bin_events   <= evt_base[OUT_W-1:0];
            end
        end
    end

endmodule

FILE: design/book_top_depletion_histogram_core.sv
`timescale 1ns / 1ps
// Top-of-book depletion histogram. Each transaction on s_ is one level pair of a
// previous/current snapshot (cmd 0) or a read of one bin (cmd 1); only reads give
// a transaction on m_, carrying the low 63 bits of both 64-bit counters. The block
// takes one transaction per cycle while the queue has room and no clear runs: a
// combinational classifier compares the level against the previous best and posts
// at most one histogram operation to a four-entry queue, and an update engine does
// one read-modify-write of both counter memories per cycle unless m_ready holds a
// read result, with forwarding between neighboring updates, so a read sees every
// earlier transaction. After reset the counter memories are cleared one bin per
// cycle, with s_ready low.
module book_top_depletion_histogram_core import bth_pkg::*; #(
    parameter int BINS   = 16384,
    parameter int LEVELS = 8
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic q_full;
    logic clr_busy;
    logic push;
    op_t  push_op;
    logic pop;
    logic q_valid;
    op_t  q_op;

    bth_front #(
        .BINS   (BINS),
        .LEVELS (LEVELS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_full   (q_full),
        .clr_busy (clr_busy),
        .push     (push),
        .push_op  (push_op)
    );

    bth_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (pop),
        .q_valid (q_valid),
        .q_op    (q_op)
    );

    bth_back #(
        .BINS (BINS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_op     (q_op),
        .pop      (pop),
        .clr_busy (clr_busy),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
